>>> rtl/core/dmos_pkg.sv
// dmos_pkg: shared types and codes for the dual mode ordered id set
// holds payload structs, action and status codes, controller states and datapath ops
// no dependencies
package dmos_pkg;

  localparam int DEPTH_DEFAULT = 64;
  localparam int ID_W = 32;
  localparam int ACT_W = 3;
  localparam int POS_W = 7;

  localparam logic [ACT_W-1:0] ACT_TEST = 3'd0;
  localparam logic [ACT_W-1:0] ACT_APPEND = 3'd1;
  localparam logic [ACT_W-1:0] ACT_REMOVE = 3'd2;
  localparam logic [ACT_W-1:0] ACT_CLEAR = 3'd3;
  localparam logic [ACT_W-1:0] ACT_SORT_ASC = 3'd4;
  localparam logic [ACT_W-1:0] ACT_SORT_DESC = 3'd5;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_PRESENT = 2'd1;
  localparam logic [1:0] ST_ABSENT = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic [ID_W-1:0]  game_id;
  } in_t;

  typedef struct packed {
    logic             found;
    logic [1:0]       status;
    logic [POS_W-1:0] position;
    logic [POS_W-1:0] count_after;
    logic             sorted_now;
  } out_t;

  typedef enum logic [4:0] {
    S_IDLE, S_SCAN_RD, S_SCAN_CMP, S_HIT, S_MISS, S_SHR_RD, S_SHR_WR,
    S_SHL_RD, S_SHL_WR, S_PUT, S_SORT_INIT, S_SORT_RDA, S_SORT_RDB,
    S_SORT_CMP, S_SORT_WRA, S_SORT_WRB, S_SORT_NEXT, S_DONE
  } state_t;

  typedef enum logic [4:0] {
    DP_NOP, DP_LOAD, DP_SCAN_RD, DP_SCAN_HIT, DP_SCAN_NEXT, DP_SET_ABSENT,
    DP_SET_PRESENT, DP_SET_FULL, DP_SHR_INIT, DP_SHR_RD, DP_SHR_WR, DP_SHL_RD,
    DP_SHL_WR, DP_PUT, DP_REMOVE_END, DP_SORT_INIT, DP_SORT_RDA, DP_SORT_RDB,
    DP_SORT_CMP, DP_SORT_WRA, DP_SORT_WRB, DP_SORT_NEXT, DP_SORT_PASS,
    DP_SORT_DONE
  } dp_op_t;

  typedef struct packed {
    logic [ACT_W-1:0] act;
    logic             sorted;
    logic             hit;
    logic             beyond;
    logic             scan_end;
    logic             shr_end;
    logic             shl_end;
    logic             pair_end;
    logic             pass_last;
    logic             swap;
    logic             full;
    logic             few;
  } dp_status_t;

endpackage

>>> rtl/core/dual_mode_ordered_id_set.sv
// dual_mode_ordered_id_set: top level, a bounded set of 32-bit ids in sorted or unsorted mode
// depends on dmos_pkg, dmos_ctrl, dmos_datapath (which holds dmos_ram)
//
// usage: drive in_item with an action and an id and raise start; the beat is
// taken at a clock edge where start is high and busy is low. busy stays high
// until the result has been shown. exactly one result per beat appears on
// out_item for one cycle, marked by out_valid; it cannot be held off.
// the ids live in a ram with one write port and one registered read port, so
// every step is a ram access: lookups scan from the front one entry at a
// time (sorted mode stops at the first larger id), inserts and removals shift
// the moved entries one at a time, and sorts run bubble passes over adjacent
// pairs. clear and unused codes go straight to the result. an append or
// remove shifts from the index where the scan stopped.
// reset empties the set and selects unsorted mode; the ram needs no clearing
// pass since only entries below the count are ever read.
module dual_mode_ordered_id_set #(
  parameter int DEPTH = dmos_pkg::DEPTH_DEFAULT
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  dmos_pkg::in_t  in_item,
  output logic           out_valid,
  output dmos_pkg::out_t out_item
);

  dmos_pkg::dp_op_t     op;
  dmos_pkg::dp_status_t status;

  dmos_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .action    (in_item.action),
    .status    (status),
    .op        (op),
    .busy      (busy),
    .out_valid (out_valid)
  );

  dmos_datapath #(.DEPTH(DEPTH)) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .op       (op),
    .status   (status),
    .out_item (out_item)
  );

endmodule

>>> rtl/core/dmos_ram.sv
// dmos_ram: generic single write port, single read port ram with registered read
// no dependencies
module dmos_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/core/dmos_ctrl.sv
// dmos_ctrl: sequencer for scan, shift, insert and bubble sort passes
// depends on dmos_pkg for states, datapath ops and status struct
module dmos_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [dmos_pkg::ACT_W-1:0]   action,
  input  dmos_pkg::dp_status_t         status,
  output dmos_pkg::dp_op_t             op,
  output logic                         busy,
  output logic                         out_valid
);

  dmos_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dmos_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    op = dmos_pkg::DP_NOP;
    unique case (state_r)
      dmos_pkg::S_IDLE: begin
        if (start) begin
          op = dmos_pkg::DP_LOAD;
          case (action) inside
            dmos_pkg::ACT_TEST, dmos_pkg::ACT_APPEND, dmos_pkg::ACT_REMOVE:
              state_nxt = dmos_pkg::S_SCAN_RD;
            dmos_pkg::ACT_SORT_ASC, dmos_pkg::ACT_SORT_DESC:
              state_nxt = dmos_pkg::S_SORT_INIT;
            default: state_nxt = dmos_pkg::S_DONE;
          endcase
        end
      end
      dmos_pkg::S_SCAN_RD: begin
        if (status.scan_end) begin
          state_nxt = dmos_pkg::S_MISS;
        end else begin
          op = dmos_pkg::DP_SCAN_RD;
          state_nxt = dmos_pkg::S_SCAN_CMP;
        end
      end
      dmos_pkg::S_SCAN_CMP: begin
        if (status.hit) begin
          op = dmos_pkg::DP_SCAN_HIT;
          state_nxt = dmos_pkg::S_HIT;
        end else if (status.beyond) begin
          // sorted mode: index is the insertion point
          state_nxt = dmos_pkg::S_MISS;
        end else begin
          op = dmos_pkg::DP_SCAN_NEXT;
          state_nxt = dmos_pkg::S_SCAN_RD;
        end
      end
      dmos_pkg::S_HIT: begin
        case (status.act)
          dmos_pkg::ACT_APPEND: begin
            op = dmos_pkg::DP_SET_PRESENT;
            state_nxt = status.sorted ? dmos_pkg::S_DONE : dmos_pkg::S_SHL_RD;
          end
          dmos_pkg::ACT_REMOVE: state_nxt = dmos_pkg::S_SHL_RD;
          default: state_nxt = dmos_pkg::S_DONE;
        endcase
      end
      dmos_pkg::S_MISS: begin
        if (status.act == dmos_pkg::ACT_APPEND) begin
          if (status.full) begin
            op = dmos_pkg::DP_SET_FULL;
            state_nxt = dmos_pkg::S_DONE;
          end else begin
            op = dmos_pkg::DP_SHR_INIT;
            state_nxt = dmos_pkg::S_SHR_RD;
          end
        end else begin
          op = dmos_pkg::DP_SET_ABSENT;
          state_nxt = dmos_pkg::S_DONE;
        end
      end
      dmos_pkg::S_SHR_RD: begin
        if (status.shr_end) begin
          state_nxt = dmos_pkg::S_PUT;
        end else begin
          op = dmos_pkg::DP_SHR_RD;
          state_nxt = dmos_pkg::S_SHR_WR;
        end
      end
      dmos_pkg::S_SHR_WR: begin
        op = dmos_pkg::DP_SHR_WR;
        state_nxt = dmos_pkg::S_SHR_RD;
      end
      dmos_pkg::S_SHL_RD: begin
        if (status.shl_end) begin
          if (status.act == dmos_pkg::ACT_APPEND) begin
            state_nxt = dmos_pkg::S_PUT;
          end else begin
            op = dmos_pkg::DP_REMOVE_END;
            state_nxt = dmos_pkg::S_DONE;
          end
        end else begin
          op = dmos_pkg::DP_SHL_RD;
          state_nxt = dmos_pkg::S_SHL_WR;
        end
      end
      dmos_pkg::S_SHL_WR: begin
        op = dmos_pkg::DP_SHL_WR;
        state_nxt = dmos_pkg::S_SHL_RD;
      end
      dmos_pkg::S_PUT: begin
        op = dmos_pkg::DP_PUT;
        state_nxt = dmos_pkg::S_DONE;
      end
      dmos_pkg::S_SORT_INIT: begin
        if (status.few) begin
          op = dmos_pkg::DP_SORT_DONE;
          state_nxt = dmos_pkg::S_DONE;
        end else begin
          op = dmos_pkg::DP_SORT_INIT;
          state_nxt = dmos_pkg::S_SORT_RDA;
        end
      end
      dmos_pkg::S_SORT_RDA: begin
        op = dmos_pkg::DP_SORT_RDA;
        state_nxt = dmos_pkg::S_SORT_RDB;
      end
      dmos_pkg::S_SORT_RDB: begin
        op = dmos_pkg::DP_SORT_RDB;
        state_nxt = dmos_pkg::S_SORT_CMP;
      end
      dmos_pkg::S_SORT_CMP: begin
        op = dmos_pkg::DP_SORT_CMP;
        state_nxt = status.swap ? dmos_pkg::S_SORT_WRA : dmos_pkg::S_SORT_NEXT;
      end
      dmos_pkg::S_SORT_WRA: begin
        op = dmos_pkg::DP_SORT_WRA;
        state_nxt = dmos_pkg::S_SORT_WRB;
      end
      dmos_pkg::S_SORT_WRB: begin
        op = dmos_pkg::DP_SORT_WRB;
        state_nxt = dmos_pkg::S_SORT_NEXT;
      end
      dmos_pkg::S_SORT_NEXT: begin
        if (status.pair_end) begin
          if (status.pass_last) begin
            op = dmos_pkg::DP_SORT_DONE;
            state_nxt = dmos_pkg::S_DONE;
          end else begin
            op = dmos_pkg::DP_SORT_PASS;
            state_nxt = dmos_pkg::S_SORT_RDA;
          end
        end else begin
          op = dmos_pkg::DP_SORT_NEXT;
          state_nxt = dmos_pkg::S_SORT_RDA;
        end
      end
      dmos_pkg::S_DONE: state_nxt = dmos_pkg::S_IDLE;
      default: state_nxt = dmos_pkg::S_IDLE;
    endcase
  end

  assign busy = (state_r != dmos_pkg::S_IDLE);
  assign out_valid = (state_r == dmos_pkg::S_DONE);

endmodule

>>> rtl/core/dmos_datapath.sv
// dmos_datapath: id store, count, mode flag, scan index and result registers
// depends on dmos_pkg and dmos_ram
module dmos_datapath #(
  parameter int DEPTH = dmos_pkg::DEPTH_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dmos_pkg::in_t        in_item,
  input  dmos_pkg::dp_op_t     op,
  output dmos_pkg::dp_status_t status,
  output dmos_pkg::out_t       out_item
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);
  localparam int IW = dmos_pkg::ID_W;
  localparam int PW = dmos_pkg::POS_W;

  logic [CW-1:0] count_r, count_nxt;
  logic          sorted_r, sorted_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] pos_r, pos_nxt;
  logic [CW-1:0] pass_r, pass_nxt;
  logic          found_r, found_nxt;
  logic [1:0]    status_r, status_nxt;
  logic [dmos_pkg::ACT_W-1:0] act_r, act_nxt;
  logic [IW-1:0] key_r, key_nxt;
  logic [IW-1:0] a_r, a_nxt;
  logic [IW-1:0] b_r, b_nxt;

  logic          we;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  logic [IW-1:0] wdata;
  logic [IW-1:0] rdata;

  logic [CW:0]   idx_p1;
  logic [CW:0]   idx_p2;
  logic [CW-1:0] idx_m1;

  assign idx_p1 = {1'b0, idx_r} + (CW+1)'(1);
  assign idx_p2 = {1'b0, idx_r} + (CW+1)'(2);
  assign idx_m1 = idx_r - CW'(1);

  dmos_ram #(.WIDTH(IW), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    count_nxt = count_r;
    sorted_nxt = sorted_r;
    idx_nxt = idx_r;
    pos_nxt = pos_r;
    pass_nxt = pass_r;
    found_nxt = found_r;
    status_nxt = status_r;
    act_nxt = act_r;
    key_nxt = key_r;
    a_nxt = a_r;
    b_nxt = b_r;
    we = 1'b0;
    waddr = AW'(idx_r);
    wdata = rdata;
    raddr = AW'(idx_r);
    unique case (op)
      dmos_pkg::DP_LOAD: begin
        act_nxt = in_item.action;
        key_nxt = in_item.game_id;
        idx_nxt = '0;
        pos_nxt = '0;
        found_nxt = 1'b0;
        status_nxt = dmos_pkg::ST_DONE;
        if (in_item.action == dmos_pkg::ACT_CLEAR) begin
          count_nxt = '0;
        end
      end
      dmos_pkg::DP_SCAN_RD: raddr = AW'(idx_r);
      dmos_pkg::DP_SCAN_HIT: begin
        found_nxt = 1'b1;
        pos_nxt = idx_r;
      end
      dmos_pkg::DP_SCAN_NEXT: idx_nxt = idx_p1[CW-1:0];
      dmos_pkg::DP_SET_ABSENT: status_nxt = dmos_pkg::ST_ABSENT;
      dmos_pkg::DP_SET_PRESENT: status_nxt = dmos_pkg::ST_PRESENT;
      dmos_pkg::DP_SET_FULL: status_nxt = dmos_pkg::ST_FULL;
      dmos_pkg::DP_SHR_INIT: begin
        pos_nxt = idx_r;
        idx_nxt = count_r;
      end
      dmos_pkg::DP_SHR_RD: raddr = AW'(idx_m1);
      dmos_pkg::DP_SHR_WR: begin
        we = 1'b1;
        idx_nxt = idx_m1;
      end
      dmos_pkg::DP_SHL_RD: raddr = AW'(idx_p1);
      dmos_pkg::DP_SHL_WR: begin
        we = 1'b1;
        idx_nxt = idx_p1[CW-1:0];
      end
      dmos_pkg::DP_PUT: begin
        we = 1'b1;
        wdata = key_r;
        // new id grows the set, a moved id keeps the count
        if (!found_r) begin
          count_nxt = count_r + CW'(1);
        end
      end
      dmos_pkg::DP_REMOVE_END: count_nxt = count_r - CW'(1);
      dmos_pkg::DP_SORT_INIT: begin
        idx_nxt = '0;
        pass_nxt = count_r - CW'(1);
      end
      dmos_pkg::DP_SORT_RDA: raddr = AW'(idx_r);
      dmos_pkg::DP_SORT_RDB: begin
        raddr = AW'(idx_p1);
        a_nxt = rdata;
      end
      dmos_pkg::DP_SORT_CMP: b_nxt = rdata;
      dmos_pkg::DP_SORT_WRA: begin
        we = 1'b1;
        wdata = b_r;
      end
      dmos_pkg::DP_SORT_WRB: begin
        we = 1'b1;
        waddr = AW'(idx_p1);
        wdata = a_r;
      end
      dmos_pkg::DP_SORT_NEXT: idx_nxt = idx_p1[CW-1:0];
      dmos_pkg::DP_SORT_PASS: begin
        idx_nxt = '0;
        pass_nxt = pass_r - CW'(1);
      end
      dmos_pkg::DP_SORT_DONE: sorted_nxt = (act_r == dmos_pkg::ACT_SORT_ASC);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      sorted_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      sorted_r <= sorted_nxt;
    end
    idx_r <= idx_nxt;
    pos_r <= pos_nxt;
    pass_r <= pass_nxt;
    found_r <= found_nxt;
    status_r <= status_nxt;
    act_r <= act_nxt;
    key_r <= key_nxt;
    a_r <= a_nxt;
    b_r <= b_nxt;
  end

  always_comb begin
    status.act = act_r;
    status.sorted = sorted_r;
    status.hit = (rdata == key_r);
    status.beyond = sorted_r && (rdata > key_r);
    status.scan_end = (idx_r == count_r);
    status.shr_end = (idx_r == pos_r);
    status.shl_end = (idx_p1 >= {1'b0, count_r});
    status.pair_end = (idx_p2 >= {1'b0, count_r});
    status.pass_last = (pass_r == CW'(1));
    status.swap = (act_r == dmos_pkg::ACT_SORT_ASC) ? (a_r > rdata) : (a_r < rdata);
    status.full = (count_r >= CW'(DEPTH));
    status.few = (count_r < CW'(2));
  end

  assign out_item.found = found_r;
  assign out_item.status = status_r;
  assign out_item.position = PW'(pos_r);
  assign out_item.count_after = PW'(count_r);
  assign out_item.sorted_now = sorted_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("stored count above depth");

  a_put_room: assert property (@(posedge clk) disable iff (!rst_n)
    (op == dmos_pkg::DP_PUT && !found_r) |-> (count_r < CW'(DEPTH)))
    else $error("insert into a full store");

  a_hit_match: assert property (@(posedge clk) disable iff (!rst_n)
    (op == dmos_pkg::DP_SCAN_HIT) |=> (found_r && pos_r == $past(idx_r)))
    else $error("hit not recorded at scan index");

endmodule
